// ----- hdl/lsi_pkg.sv -----
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants for the text line start indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Register indexes on the configuration port
    localparam logic REG_START_LINE   = 1'b0;
    localparam logic REG_START_COLUMN = 1'b1;

    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_ENABLE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_scan_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic [31:0] location;
    } t_in_item;

    typedef struct packed {
        logic [31:0] line_number;
        logic [31:0] column;
        logic        beyond_end;
        logic        table_overflow;
    } t_out_item;

    // Query request handed to the scan unit
    typedef struct packed {
        logic        start;
        logic [31:0] pos;
        logic [31:0] run_loc;
    } t_scan_req;

    // Scan result, held until taken
    typedef struct packed {
        logic        valid;
        logic [31:0] column;
        logic        beyond_end;
    } t_scan_res;

endpackage

`default_nettype wire

// ----- hdl/text_line_start_indexer.sv -----
// ----------------------------------------------------------------------------
// text_line_start_indexer
// Records line starts of a byte stream and answers location queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one request per
//   accepted edge: a stream byte, a location query, disable or enable.
//   Bytes, disable and enable produce nothing, so a byte can be accepted
//   every cycle while no query holds the input. Every newline taken while
//   enabled, if the line start table RAM has room, writes the location of
//   the following byte into it. A query stalls the input while the scan
//   unit reads the table one entry per cycle from the start until the
//   location is placed; an empty table skips the scan. o_out_valid rises
//   once the output register takes the result; the input reopens in the same cycle.
//   Output channel (o_out_valid / i_out_stall / o_out) is a register; while
//   it is stalled, bytes keep flowing and a finished query waits in the scan
//   unit, holding the input stalled until the output register frees up.
//   start_line and start_column are written over the APB-style port at
//   byte addresses 0 and 4; pready is always high.
//   Reset: counting enabled, table empty, first byte initializes the running
//   location from its location field, registers cleared. Table RAM contents
//   are not cleared; only entries below the line count decide a query.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_start_indexer #(
    parameter int MAX_LINES = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lsi_pkg::t_in_item   i_in,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lsi_pkg::t_out_item       o_out,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    // configuration
    logic [31:0] r_start_line;
    logic [31:0] r_start_column;

    // stream state
    logic          r_enabled;
    logic          r_init;        // next byte re-bases the stream
    logic [31:0]   r_running;
    logic [CW-1:0] r_count;
    logic          r_overflow;

    logic              r_out_valid;
    lsi_pkg::t_out_item r_out;

    // byte path
    logic          w_accept;
    logic          w_byte;
    logic [CW-1:0] w_eff_count;
    logic          w_eff_ovf;
    logic [31:0]   w_eff_run;
    logic          w_newline;
    logic          w_room;
    logic          w_we;

    // scan interface
    lsi_pkg::t_scan_req w_req;
    lsi_pkg::t_scan_res w_res;
    logic               w_busy;
    logic               w_take;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [31:0]        w_rd_data;
    logic [CW-1:0]      w_line_idx;
    logic               w_out_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            lsi_pkg::REG_START_LINE:   prdata = r_start_line;
            lsi_pkg::REG_START_COLUMN: prdata = r_start_column;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_line   <= '0;
            r_start_column <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                lsi_pkg::REG_START_LINE:   r_start_line   <= pwdata;
                lsi_pkg::REG_START_COLUMN: r_start_column <= pwdata;
                default: ;
            endcase
        end
    end

    // ---------------- request intake ----------------
    // Queries hold off all further requests until their result is handed over.
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_byte     = w_accept && (i_in.cmd == lsi_pkg::CMD_DATA) && r_enabled;

    // first byte after arming starts from an empty table at its own location
    assign w_eff_count = r_init ? '0 : r_count;
    assign w_eff_ovf   = r_init ? 1'b0 : r_overflow;
    assign w_eff_run   = r_init ? i_in.location : r_running;
    assign w_newline   = i_in.data_byte == lsi_pkg::NEWLINE_BYTE;
    assign w_room      = w_eff_count < CW'(MAX_LINES);
    assign w_we        = w_byte && w_newline && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b1;
            r_init     <= 1'b1;
            r_running  <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (w_accept) begin
            unique case (i_in.cmd)
                lsi_pkg::CMD_DATA: begin
                    if (r_enabled) begin
                        r_init     <= 1'b0;
                        r_running  <= w_eff_run + 32'd1;
                        r_count    <= (w_newline && w_room) ? w_eff_count + CW'(1)
                                                            : w_eff_count;
                        r_overflow <= w_eff_ovf || (w_newline && !w_room);
                    end
                end
                lsi_pkg::CMD_QUERY: ;
                lsi_pkg::CMD_DISABLE: begin
                    r_enabled <= 1'b0;
                end
                lsi_pkg::CMD_ENABLE: begin
                    // re-arm only from disabled; a pending re-base stays pending
                    if (!r_enabled) begin
                        r_enabled <= 1'b1;
                        r_init    <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- line start table ----------------
    lsi_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LINES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_eff_count[AW-1:0]),
        .i_wdata (w_eff_run + 32'd1),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // ---------------- query scan ----------------
    // A query before the first byte after re-arming sees the old table.
    assign w_req.start   = w_accept && (i_in.cmd == lsi_pkg::CMD_QUERY);
    assign w_req.pos     = i_in.location;
    assign w_req.run_loc = r_running;

    lsi_scan #(
        .MAX_LINES (MAX_LINES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_count        (r_count),
        .i_start_column (r_start_column),
        .i_take         (w_take),
        .o_busy         (w_busy),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_res          (w_res),
        .o_line_idx     (w_line_idx)
    );

    // ---------------- result register ----------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take     = w_res.valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.line_number    <= r_start_line + 32'(w_line_idx);
            r_out.column         <= w_res.column;
            r_out.beyond_end     <= w_res.beyond_end;
            r_out.table_overflow <= r_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- hdl/lsi_ram.sv -----
// ----------------------------------------------------------------------------
// lsi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lsi_scan.sv -----
// ----------------------------------------------------------------------------
// lsi_scan
// Query engine: walks the line start table one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_scan #(
    parameter int MAX_LINES = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lsi_pkg::t_scan_req                 i_req,
    input  wire logic [$clog2(MAX_LINES+1)-1:0]     i_count,
    input  wire logic [31:0]                        i_start_column,
    input  wire logic                               i_take,
    output logic                                    o_busy,
    output logic                                    o_rd_en,
    output logic      [$clog2(MAX_LINES)-1:0]       o_rd_addr,
    input  wire logic [31:0]                        i_rd_data,
    output lsi_pkg::t_scan_res                      o_res,
    output logic      [$clog2(MAX_LINES+1)-1:0]     o_line_idx
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    lsi_pkg::t_scan_state r_state, n_state;

    logic [31:0]   r_pos;
    logic [31:0]   r_run;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_issue;
    logic          r_chk_valid;
    logic [CW-1:0] r_chk_idx;
    logic [31:0]   r_prev;
    logic [CW-1:0] r_line;
    logic [31:0]   r_col;
    logic          r_beyond;

    logic w_decide;
    logic w_past;       // location lies beyond the entry just read
    logic w_last;       // entry just read is the last recorded one

    assign w_decide = (r_state == lsi_pkg::ST_SCAN) && r_chk_valid;
    assign w_past   = r_pos > i_rd_data;
    assign w_last   = r_chk_idx == (r_n - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsi_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_count == '0) ? lsi_pkg::ST_FINISH : lsi_pkg::ST_SCAN;
                end
            end
            lsi_pkg::ST_SCAN: begin
                if (w_decide && (!w_past || w_last)) begin
                    n_state = lsi_pkg::ST_FINISH;
                end
            end
            lsi_pkg::ST_FINISH: begin
                if (i_take) begin
                    n_state = lsi_pkg::ST_IDLE;
                end
            end
            default: n_state = lsi_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy           = r_state != lsi_pkg::ST_IDLE;
        o_rd_en          = r_state == lsi_pkg::ST_SCAN;
        o_rd_addr        = r_issue[AW-1:0];
        o_res.valid      = r_state == lsi_pkg::ST_FINISH;
        o_res.column     = r_col;
        o_res.beyond_end = r_beyond;
        o_line_idx       = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lsi_pkg::ST_IDLE && i_req.start) begin
            r_pos       <= i_req.pos;
            r_run       <= i_req.run_loc;
            r_n         <= i_count;
            r_issue     <= '0;
            r_chk_valid <= 1'b0;
            // empty table: whole stream is the first line
            r_line      <= '0;
            r_col       <= i_start_column + i_req.pos;
            r_beyond    <= 1'b0;
        end else if (r_state == lsi_pkg::ST_SCAN) begin
            r_issue     <= r_issue + CW'(1);
            r_chk_valid <= 1'b1;
            r_chk_idx   <= r_issue;
            if (w_decide) begin
                r_prev <= i_rd_data;
                if (w_past) begin
                    if (w_last) begin
                        r_line   <= r_n;
                        r_beyond <= r_pos > r_run;
                        r_col    <= (r_pos > r_run) ? 32'd0 : r_pos - i_rd_data;
                    end
                end else if (r_pos == i_rd_data) begin
                    // exactly on a line start: first column of that line
                    r_line <= r_chk_idx + CW'(1);
                    r_col  <= 32'd0;
                end else begin
                    r_line <= r_chk_idx;
                    r_col  <= (r_chk_idx == '0) ? i_start_column + r_pos : r_pos - r_prev;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lsi_checker.sv -----
// ----------------------------------------------------------------------------
// lsi_checker
// Port-level checks for the text line start indexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire lsi_pkg::t_in_item  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire lsi_pkg::t_out_item o_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // column is zeroed whenever the location is past the stream end
    a_beyond_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.beyond_end |-> o_out.column == 32'd0)
        else $error("beyond_end with nonzero column");

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted query blocks further requests while it is answered
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.cmd == lsi_pkg::CMD_QUERY |=> o_in_stall)
        else $error("request accepted right after a query");

endmodule

bind text_line_start_indexer lsi_checker u_lsi_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_line_start_indexer. It drives random byte
// streams, location queries, disable and enable requests, and APB register
// writes. A scoreboard class keeps its own line start table and predicts
// every query answer.
// ----------------------------------------------------------------------------

module testbench;

    localparam int TABLE_DEPTH = 1024;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the indexer state, predicts query answers and
    // compares them in order against what comes out of the block.
    // ------------------------------------------------------------------------
    class line_index_scoreboard;
        logic [31:0] start_line;
        logic [31:0] start_column;
        bit          enabled;
        bit          init_pending;
        bit          overflow;
        logic [31:0] run_loc;
        logic [31:0] line_starts [TABLE_DEPTH];
        int unsigned line_count;
        lsi_pkg::t_out_item pending_positions [$];
        int unsigned mismatches;

        function new();
            start_line   = '0;
            start_column = '0;
            enabled      = 1'b1;
            init_pending = 1'b1;
            overflow     = 1'b0;
            run_loc      = '0;
            line_count   = 0;
            mismatches   = 0;
            foreach (line_starts[i]) line_starts[i] = '0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == lsi_pkg::REG_START_LINE) begin
                start_line = value;
            end else begin
                start_column = value;
            end
        endfunction

        // Line and column of an absolute location against the current table
        function lsi_pkg::t_out_item locate_position(logic [31:0] pos);
            lsi_pkg::t_out_item res;
            logic [31:0] line;
            int unsigned k;
            res.column         = start_column;
            res.beyond_end     = 1'b0;
            res.table_overflow = overflow;
            line = '0;
            k    = 0;
            if (line_count == 0) begin
                res.column = start_column + pos;
            end else begin
                while (k < line_count && pos > line_starts[k]) k++;
                if (k == line_count) begin
                    // past the last newline: last line, unless past the stream end
                    line = 32'(line_count);
                    if (pos > run_loc) begin
                        res.beyond_end = 1'b1;
                        res.column     = '0;
                    end else begin
                        res.column = pos - line_starts[line_count - 1];
                    end
                end else begin
                    line = 32'(k);
                    if (pos == line_starts[k]) line = 32'(k + 1);
                    if (line == 0) begin
                        res.column = start_column + pos;
                    end else begin
                        res.column = pos - line_starts[line - 1];
                    end
                end
            end
            res.line_number = start_line + line;
            return res;
        endfunction

        function void note_request(lsi_pkg::t_in_item req);
            case (req.cmd)
                lsi_pkg::CMD_DATA: begin
                    if (enabled) begin
                        if (init_pending) begin
                            init_pending = 1'b0;
                            line_count   = 0;
                            overflow     = 1'b0;
                            run_loc      = req.location;
                        end
                        if (req.data_byte == lsi_pkg::NEWLINE_BYTE) begin
                            if (line_count < TABLE_DEPTH) begin
                                line_starts[line_count] = run_loc + 32'd1;
                                line_count++;
                            end else begin
                                overflow = 1'b1;
                            end
                        end
                        run_loc = run_loc + 32'd1;
                    end
                end
                lsi_pkg::CMD_QUERY:
                    pending_positions = {pending_positions, locate_position(req.location)};
                lsi_pkg::CMD_DISABLE: enabled = 1'b0;
                default: begin
                    if (!enabled) begin
                        enabled      = 1'b1;
                        init_pending = 1'b1;
                    end
                end
            endcase
        endfunction

        function void check_result(lsi_pkg::t_out_item got);
            lsi_pkg::t_out_item want;
            if (pending_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unrequested result line=%h col=%h beyond=%b ovf=%b",
                             got.line_number, got.column, got.beyond_end,
                             got.table_overflow);
                return;
            end
            want = pending_positions.pop_front();
            if (got.line_number !== want.line_number || got.column !== want.column ||
                got.beyond_end !== want.beyond_end ||
                got.table_overflow !== want.table_overflow) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: line=%h/%h col=%h/%h beyond=%b/%b ovf=%b/%b (exp/act)",
                             want.line_number, got.line_number, want.column, got.column,
                             want.beyond_end, got.beyond_end,
                             want.table_overflow, got.table_overflow);
            end
        endfunction

        // Query locations that land on line starts, the stream end and just around
        // them, further past the end and into the last line; a few fully random ones too.
        function logic [31:0] pick_location();
            int unsigned sel;
            int unsigned k;
            sel = $urandom_range(0, 9);
            case (sel)
                0: return $urandom();
                1, 2: begin
                    if (line_count == 0) return run_loc - 32'($urandom_range(0, 5));
                    k = $urandom_range(0, line_count - 1);
                    return line_starts[k] + 32'($urandom_range(0, 2)) - 32'd1;
                end
                3, 4: return run_loc + 32'($urandom_range(0, 2)) - 32'd1;
                5: return run_loc + 32'($urandom_range(2, 50));
                default: begin
                    if (line_count == 0) return run_loc - 32'($urandom_range(0, 20));
                    return line_starts[line_count - 1] + 32'($urandom_range(0, 20));
                end
            endcase
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    lsi_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lsi_pkg::t_out_item out_item;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    line_index_scoreboard sb = new();

    bit          sender_idle   = 1'b1;   // random gaps on the request side
    bit          receiver_idle = 1'b1;   // random stalls on the result side
    bit          hold_req      = 1'b0;   // ask the receiver for one long hold-off
    int unsigned live_items    = 0;      // requests other than bytes sent while disabled

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    text_line_start_indexer #(
        .MAX_LINES(TABLE_DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Request side. Called on a rising edge; returns on the edge at which
    // the request was taken. Valid stays high into the next call so that
    // back-to-back requests need no extra NBA in the same step.
    // ------------------------------------------------------------------------
    task automatic send_req(input lsi_pkg::t_cmd cmd, input logic [7:0] data,
                            input logic [31:0] loc);
        lsi_pkg::t_in_item req;
        req.cmd       = cmd;
        req.data_byte = data;
        req.location  = loc;
        if (sender_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        // dropped bytes while disabled do not count as useful stimulus
        if (!(cmd == lsi_pkg::CMD_DATA && !sb.enabled)) live_items++;
        sb.note_request(req);
    endtask

    // Stop offering and wait until every query answer is back, then settle
    task automatic drain(input int settle);
        int guard;
        in_valid <= 1'b0;
        for (guard = 0; guard < 200000 && sb.pending_positions.size() != 0; guard++)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle until pready, then back to idle
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Text run with random content and newline density, optionally re-armed
    // first, followed by a few queries into what was just written.
    task automatic text_burst();
        int          n;
        int          nl_pct;
        logic [31:0] base;
        n      = $urandom_range(1, 30);
        nl_pct = $urandom_range(5, 40);
        // base location near the top of the range now and then, to wrap
        base   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40))
                                             : 32'($urandom());
        if (!sb.enabled) begin
            send_req(lsi_pkg::CMD_ENABLE, 8'($urandom), $urandom());
        end else if ($urandom_range(0, 9) < 3) begin
            send_req(lsi_pkg::CMD_DISABLE, 8'($urandom), $urandom());
            send_req(lsi_pkg::CMD_ENABLE, 8'($urandom), $urandom());
        end
        repeat (n) begin
            send_req(lsi_pkg::CMD_DATA,
                     ($urandom_range(0, 99) < nl_pct) ? lsi_pkg::NEWLINE_BYTE
                                                      : 8'($urandom),
                     base);
            base = $urandom();   // only the first byte after arming uses it
        end
        repeat ($urandom_range(1, 4))
            send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.pick_location());
    endtask

    task automatic random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            text_burst();
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3))
                send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.pick_location());
        end else begin
            // noise: any command, any field bits
            repeat ($urandom_range(1, 4))
                send_req(lsi_pkg::t_cmd'($urandom_range(0, 3)), 8'($urandom), $urandom());
        end
    endtask

    // Receiver holds off for a long stretch while queries and bytes keep
    // coming: output register and scan unit fill, the input must stall.
    task automatic long_hold();
        hold_req = 1'b1;
        repeat (6) begin
            send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.pick_location());
            repeat (4) send_req(lsi_pkg::CMD_DATA, 8'($urandom), $urandom());
        end
    endtask

    // Fill past the table depth so newlines get dropped, then query the last
    // stored entry, a middle one, the stream end and just past it.
    task automatic overflow_fill();
        send_req(lsi_pkg::CMD_DISABLE, 8'($urandom), $urandom());
        send_req(lsi_pkg::CMD_ENABLE, 8'($urandom), $urandom());
        send_req(lsi_pkg::CMD_DATA, lsi_pkg::NEWLINE_BYTE, $urandom());
        while (!sb.overflow)
            send_req(lsi_pkg::CMD_DATA,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : lsi_pkg::NEWLINE_BYTE,
                     $urandom());
        repeat (8)
            send_req(lsi_pkg::CMD_DATA,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : lsi_pkg::NEWLINE_BYTE,
                     $urandom());
        send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.run_loc);
        send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.run_loc + 32'd1);
        send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.line_starts[TABLE_DEPTH - 1]);
        send_req(lsi_pkg::CMD_QUERY, 8'($urandom),
                 sb.line_starts[TABLE_DEPTH / 2] + 32'd3);
        send_req(lsi_pkg::CMD_QUERY, 8'($urandom), sb.pick_location());
    endtask

    // Directed opening: empty table, wrap of the running location, line
    // start hits, first and last line, beyond end, disable and re-arm cases.
    task automatic directed_part();
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'hFFFF_FFFF);  // empty table after reset
        send_req(lsi_pkg::CMD_DATA,    8'h41, 32'hFFFF_FFFD);  // first byte sets base
        send_req(lsi_pkg::CMD_DATA,    lsi_pkg::NEWLINE_BYTE, 32'h0000_0000);
        // next start wraps to 0
        send_req(lsi_pkg::CMD_DATA,    lsi_pkg::NEWLINE_BYTE, 32'hFFFF_FFFF);
        send_req(lsi_pkg::CMD_DATA,    8'hFF, 32'h1234_5678);
        send_req(lsi_pkg::CMD_DATA,    8'h00, 32'h0000_0000);
        send_req(lsi_pkg::CMD_QUERY,   8'hFF, 32'hFFFF_FFFD);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'hFFFF_FFFF);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0000);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0001);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0003);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0002);
        send_req(lsi_pkg::CMD_DISABLE, 8'hFF, 32'hFFFF_FFFF);
        send_req(lsi_pkg::CMD_DATA,    lsi_pkg::NEWLINE_BYTE, 32'h0000_0000);  // dropped
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0002);
        send_req(lsi_pkg::CMD_ENABLE,  8'h00, 32'h0000_0000);
        send_req(lsi_pkg::CMD_ENABLE,  8'hFF, 32'hFFFF_FFFF);  // already on: no effect
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'h0000_0001);  // old table still visible
        send_req(lsi_pkg::CMD_DISABLE, 8'h00, 32'h0000_0000);  // disable with init pending
        send_req(lsi_pkg::CMD_ENABLE,  8'h00, 32'h0000_0000);
        send_req(lsi_pkg::CMD_DATA,    lsi_pkg::NEWLINE_BYTE, 32'd100);  // clears, base 100
        send_req(lsi_pkg::CMD_DATA,    8'h7F, 32'h0000_0000);
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'd101);  // on a line start
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'd100);  // first line
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'd102);  // last line, within stream
        send_req(lsi_pkg::CMD_QUERY,   8'h00, 32'd103);  // past the end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check on every taken result, then choose the stall for
    // the next cycle. Long hold-off is counted here, in cycles.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_result(out_item);
            if (hold_req) begin
                stall_left = 400;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && receiver_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed part, then four register settings with
    // random traffic, each entered only once the block has gone quiet.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int          ph;
        int unsigned target;
        logic [31:0] line_val;
        logic [31:0] col_val;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();
        drain(4);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin line_val = 32'hFFFF_FFFF; col_val = 32'hFFFF_FFFF; end
                1: begin line_val = 32'h0;         col_val = 32'h0;         end
                2: begin line_val = $urandom();    col_val = $urandom();    end
                default: begin line_val = $urandom(); col_val = 32'h7FFF_FFFF; end
            endcase
            write_reg(lsi_pkg::REG_START_LINE, line_val);
            write_reg(lsi_pkg::REG_START_COLUMN, col_val);

            // phase 1 runs flat out on both sides
            sender_idle   = (ph != 1);
            receiver_idle = (ph != 1);
            if (ph == 1) long_hold();
            if (ph == 2) overflow_fill();

            target = live_items + 100;
            while (live_items < target) begin
                if (ph == 3 && live_items + 40 >= target) begin
                    sender_idle   = 1'b0;
                    receiver_idle = 1'b0;
                end
                random_sequence();
            end
            drain(4);
        end

        drain(16);
        if (sb.mismatches == 0 && sb.pending_positions.size() == 0) begin
            $display("text_line_start_indexer test passed");
        end else begin
            $display("text_line_start_indexer test failed");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin : watchdog
        #100_000_000;
        $display("text_line_start_indexer test failed");
        $finish;
    end

endmodule

// ----- text_line_start_indexer.f -----
hdl/lsi_pkg.sv
hdl/lsi_ram.sv
hdl/lsi_scan.sv
hdl/text_line_start_indexer.sv
hdl/lsi_checker.sv
dv/testbench.sv
